// ----- rtl/pavk_pkg.sv -----
// Shared types, constants and the CORDIC arctangent table for the planar arm
// velocity kinematics block. No dependencies.
package pavk_pkg;

    // Trig value width: Q.30 with headroom for CORDIC growth
    localparam int TRIG_W = 34;
    localparam int ZACC_W = 34;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 18;

    // CORDIC start vector, gain-corrected, Q.30
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;
    // 180/pi in Q.16
    localparam logic signed [22:0] DEG_PER_RAD = 23'sd3754936;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INNER_LEN = 3'd0,
        CFG_OUTER_LEN = 3'd1,
        CFG_X_UPPER   = 3'd2,
        CFG_X_LOWER   = 3'd3,
        CFG_Y_UPPER   = 3'd4,
        CFG_Y_LOWER   = 3'd5
    } cfg_idx_t;

    // Side information that rides alongside the divider pipeline
    typedef struct packed {
        logic signed [18:0] tip_x;
        logic signed [18:0] tip_y;
        logic               limit_hit;
        logic               singular;
    } side_t;

    // atan(2^-i) in 2^32-per-turn units
    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] val;
        case (idx)
            0:  val = 32'd536870912;
            1:  val = 32'd316933406;
            2:  val = 32'd167458907;
            3:  val = 32'd85004756;
            4:  val = 32'd42667331;
            5:  val = 32'd21354465;
            6:  val = 32'd10679838;
            7:  val = 32'd5340245;
            8:  val = 32'd2670163;
            9:  val = 32'd1335087;
            10: val = 32'd667544;
            11: val = 32'd333772;
            12: val = 32'd166886;
            13: val = 32'd83443;
            14: val = 32'd41722;
            15: val = 32'd20861;
            16: val = 32'd10430;
            17: val = 32'd5215;
            18: val = 32'd2608;
            19: val = 32'd1304;
            20: val = 32'd652;
            21: val = 32'd326;
            22: val = 32'd163;
            23: val = 32'd81;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

// ----- rtl/pavk_cordic.sv -----
// Pipelined rotation-mode CORDIC: one iteration per register stage, giving
// Q.30 cosine and sine of a 32-bit binary-turn angle. Depends on pavk_pkg.
module pavk_cordic #(
    parameter int ITER = 16
) (
    input  logic                               aclk,
    input  logic                               en,
    input  logic [31:0]                        angle,
    output logic signed [pavk_pkg::TRIG_W-1:0] cos_q,
    output logic signed [pavk_pkg::TRIG_W-1:0] sin_q
);
    import pavk_pkg::*;

    logic signed [TRIG_W-1:0] x_reg [0:ITER];
    logic signed [TRIG_W-1:0] y_reg [0:ITER];
    logic signed [ZACC_W-1:0] z_reg [0:ITER];
    logic                     flip_reg [0:ITER];

    logic [31:0] half_sum;
    logic [31:0] folded;

    // Fold the angle into [-1/4, 1/4) turn
    always_comb begin
        half_sum = angle + 32'h4000_0000;
        folded   = half_sum[31] ? (angle ^ 32'h8000_0000) : angle;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= {{(ZACC_W-32){folded[31]}}, folded};
            flip_reg[0] <= half_sum[31];
        end
    end

    // One micro-rotation per stage
    for (genvar i = 0; i < ITER; i++) begin : g_iter
        localparam logic signed [ZACC_W-1:0] ATAN =
            {{(ZACC_W-32){1'b0}}, atan_turn(i)};
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!z_reg[i][ZACC_W-1]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN;
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN;
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    // Undo the fold
    always_ff @(posedge aclk) begin
        if (en) begin
            cos_q <= flip_reg[ITER] ? -x_reg[ITER] : x_reg[ITER];
            sin_q <= flip_reg[ITER] ? -y_reg[ITER] : y_reg[ITER];
        end
    end

endmodule

// ----- rtl/pavk_div.sv -----
// Pipelined restoring divider: trunc(|num| * 2^SHIFT / |den|), one quotient
// bit per stage, with an overflow flag past 32 quotient bits. Depends on pavk_pkg.
module pavk_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 52,
    parameter int SHIFT = 6
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DEN_W-1:0] den,
    output logic [31:0]             quot,
    output logic                    ovf,
    output logic                    neg
);
    import pavk_pkg::*;

    localparam int AW = NUM_W + SHIFT;
    localparam int CW = ((AW > DEN_W + 32) ? AW : DEN_W + 32) + 1;

    logic [CW-1:0]    rem_reg  [0:32];
    logic [DEN_W-1:0] den_reg  [0:32];
    logic [31:0]      q_reg    [0:32];
    logic             ovf_reg  [0:32];
    logic             neg_reg  [0:32];

    logic [NUM_W-1:0] num_abs;
    logic [DEN_W-1:0] den_abs;
    logic [CW-1:0]    num_ext;

    // Magnitudes and the overflow test against den * 2^32
    always_comb begin
        num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        den_abs = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
        num_ext = CW'({num_abs, {SHIFT{1'b0}}});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num_ext;
            den_reg[0] <= den_abs;
            q_reg[0]   <= '0;
            ovf_reg[0] <= (num_ext >= (CW'(den_abs) << 32));
            neg_reg[0] <= num[NUM_W-1] ^ den[DEN_W-1];
        end
    end

    // Quotient bit 31-k in stage k
    for (genvar k = 0; k < 32; k++) begin : g_bit
        logic [CW-1:0] trial;
        assign trial = CW'(den_reg[k]) << (31 - k);
        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_reg[k] >= trial) begin
                    rem_reg[k+1] <= rem_reg[k] - trial;
                    q_reg[k+1]   <= q_reg[k] | (32'd1 << (31 - k));
                end else begin
                    rem_reg[k+1] <= rem_reg[k];
                    q_reg[k+1]   <= q_reg[k];
                end
                den_reg[k+1] <= den_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    assign quot = q_reg[32];
    assign ovf  = ovf_reg[32];
    assign neg  = neg_reg[32];

endmodule

// ----- rtl/planar_arm_velocity_kinematics.sv -----
// Planar arm velocity kinematics top level: forward kinematics, workspace
// limit test and inverse Jacobian. Depends on pavk_pkg, pavk_cordic, pavk_div.
//
// Each input word carries two joint angles and a tip velocity command; each
// output word carries the tip position, the two joint speeds and the limit
// and singular flags. The block takes one word per clock and returns each
// result through TRIG_ITERATIONS + 2 stages of the three parallel CORDIC
// units, five multiply and round stages, 33 stages of the two parallel
// quotient pipelines and the output register. The whole pipeline holds
// while the output word waits, so s_tready follows m_tready when the output
// register is full. Configuration writes take effect at once and must only
// be issued while no word is in flight.
module planar_arm_velocity_kinematics #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // cfg_wdata: register value in the low bits
    input  logic                               cfg_we,
    input  logic [pavk_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [pavk_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // s_tdata: shoulder_angle[15:0], elbow_angle[31:16],
    //          tip_x_speed[51:32], tip_y_speed[71:52]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [71:0]                        s_tdata,
    // m_tdata: shoulder_speed[31:0], elbow_speed[63:32],
    //          tip_x[82:64], tip_y[101:83], zero fill above
    // m_tuser: limit_hit[0], singular[1]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [103:0]                       m_tdata,
    output logic [1:0]                         m_tuser
);
    import pavk_pkg::*;

    localparam int CORDIC_LAT = TRIG_ITERATIONS + 2;
    localparam int NV = TRIG_ITERATIONS + 41;
    localparam logic signed [TRIG_W-1:0] SIN_THR =
        TRIG_W'(1) << (32 - TRIG_ITERATIONS);

    // Configuration registers
    logic [16:0]        inner_len_reg;
    logic [16:0]        outer_len_reg;
    logic signed [17:0] x_upper_reg;
    logic signed [17:0] x_lower_reg;
    logic signed [17:0] y_upper_reg;
    logic signed [17:0] y_lower_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inner_len_reg <= 17'd28574;
            outer_len_reg <= 17'd24576;
            x_upper_reg   <= 18'sd19661;
            x_lower_reg   <= -18'sd19661;
            y_upper_reg   <= 18'sd42271;
            y_lower_reg   <= 18'sd21627;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_INNER_LEN: inner_len_reg <= cfg_wdata[16:0];
                CFG_OUTER_LEN: outer_len_reg <= cfg_wdata[16:0];
                CFG_X_UPPER:   x_upper_reg   <= cfg_wdata;
                CFG_X_LOWER:   x_lower_reg   <= cfg_wdata;
                CFG_Y_UPPER:   y_upper_reg   <= cfg_wdata;
                CFG_Y_LOWER:   y_lower_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic signed [17:0] li_s;
    logic signed [17:0] lo_s;
    assign li_s = {1'b0, inner_len_reg};
    assign lo_s = {1'b0, outer_len_reg};

    // Advance the whole pipeline unless the output word is stalled
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    logic vld_reg [0:NV-1];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NV; i++) vld_reg[i] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < NV; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end
    assign m_tvalid = vld_reg[NV-1];

    // Input angles as 32-bit turns
    logic [31:0] ang_s;
    logic [31:0] ang_e;
    logic [31:0] ang_se;
    assign ang_s  = {s_tdata[15:0], 16'h0000};
    assign ang_e  = {s_tdata[31:16], 16'h0000};
    assign ang_se = ang_s + ang_e;

    logic signed [TRIG_W-1:0] cs, ss, c12, s12, ce, se;

    pavk_cordic #(.ITER(TRIG_ITERATIONS)) u_cordic_s (
        .aclk(aclk), .en(adv), .angle(ang_s), .cos_q(cs), .sin_q(ss));
    pavk_cordic #(.ITER(TRIG_ITERATIONS)) u_cordic_se (
        .aclk(aclk), .en(adv), .angle(ang_se), .cos_q(c12), .sin_q(s12));
    pavk_cordic #(.ITER(TRIG_ITERATIONS)) u_cordic_e (
        .aclk(aclk), .en(adv), .angle(ang_e), .cos_q(ce), .sin_q(se));

    // Carry the speed command alongside the CORDIC stages
    logic signed [19:0] vx_d [0:CORDIC_LAT-1];
    logic signed [19:0] vy_d [0:CORDIC_LAT-1];
    always_ff @(posedge aclk) begin
        if (adv) begin
            vx_d[0] <= s_tdata[51:32];
            vy_d[0] <= s_tdata[71:52];
            for (int i = 1; i < CORDIC_LAT; i++) begin
                vx_d[i] <= vx_d[i-1];
                vy_d[i] <= vy_d[i-1];
            end
        end
    end

    // P1: products of lengths and speeds with the trig values
    logic signed [51:0] lc12_reg, lcs_reg, ls12_reg, lss_reg, d1_p1_reg;
    logic signed [53:0] xc12_reg, ys12_reg, xcs_reg, yss_reg;
    logic signed [TRIG_W-1:0] se_p1_reg;
    logic signed [19:0] vx_p1_reg, vy_p1_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            lc12_reg  <= lo_s * c12;
            lcs_reg   <= li_s * cs;
            ls12_reg  <= lo_s * s12;
            lss_reg   <= li_s * ss;
            d1_p1_reg <= li_s * se;
            xc12_reg  <= vx_d[CORDIC_LAT-1] * c12;
            ys12_reg  <= vy_d[CORDIC_LAT-1] * s12;
            xcs_reg   <= vx_d[CORDIC_LAT-1] * cs;
            yss_reg   <= vy_d[CORDIC_LAT-1] * ss;
            se_p1_reg <= se;
            vx_p1_reg <= vx_d[CORDIC_LAT-1];
            vy_p1_reg <= vy_d[CORDIC_LAT-1];
        end
    end

    // P2: sum, round and clamp tip position; round projections
    logic signed [52:0] sum_x, sum_y, shx, shy;
    logic signed [54:0] sum_p, sum_q, shp, shq;
    logic signed [51:0] shd;
    logic signed [18:0] tx_next, ty_next;
    always_comb begin
        sum_x = lc12_reg + lcs_reg;
        sum_y = ls12_reg + lss_reg;
        shx   = (sum_x + 53'sd536870912) >>> 30;
        shy   = (sum_y + 53'sd536870912) >>> 30;
        sum_p = xc12_reg + ys12_reg;
        sum_q = xcs_reg + yss_reg;
        shp   = (sum_p + 55'sd8192) >>> 14;
        shq   = (sum_q + 55'sd8192) >>> 14;
        shd   = (d1_p1_reg + 52'sd8192) >>> 14;
        if (shx > 53'sd262143)       tx_next = 19'sd262143;
        else if (shx < -53'sd262144) tx_next = -19'sd262144;
        else                         tx_next = shx[18:0];
        if (shy > 53'sd262143)       ty_next = 19'sd262143;
        else if (shy < -53'sd262144) ty_next = -19'sd262144;
        else                         ty_next = shy[18:0];
    end

    logic signed [18:0] tx_p2_reg, ty_p2_reg;
    logic signed [40:0] p16_reg, q16_reg;
    logic signed [37:0] rd1_reg;
    logic signed [51:0] d1_p2_reg;
    logic               sing_p2_reg;
    logic signed [19:0] vx_p2_reg, vy_p2_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            tx_p2_reg   <= tx_next;
            ty_p2_reg   <= ty_next;
            p16_reg     <= shp[40:0];
            q16_reg     <= shq[40:0];
            rd1_reg     <= shd[37:0];
            d1_p2_reg   <= d1_p1_reg;
            sing_p2_reg <= (se_p1_reg < SIN_THR && se_p1_reg > -SIN_THR) ||
                           (d1_p1_reg == '0);
            vx_p2_reg   <= vx_p1_reg;
            vy_p2_reg   <= vy_p1_reg;
        end
    end

    // P3: limit test and second round of products
    logic signed [55:0] d2_reg;
    logic signed [58:0] mlp_reg, mlq_reg;
    logic signed [63:0] num1_p3_reg;
    logic signed [51:0] d1_p3_reg;
    logic signed [18:0] tx_p3_reg, ty_p3_reg;
    logic               lim_p3_reg, sing_p3_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            d2_reg      <= rd1_reg * lo_s;
            mlp_reg     <= lo_s * p16_reg;
            mlq_reg     <= li_s * q16_reg;
            num1_p3_reg <= p16_reg * DEG_PER_RAD;
            d1_p3_reg   <= d1_p2_reg;
            tx_p3_reg   <= tx_p2_reg;
            ty_p3_reg   <= ty_p2_reg;
            sing_p3_reg <= sing_p2_reg;
            lim_p3_reg  <= (tx_p2_reg > x_upper_reg && vx_p2_reg > 20'sd0) ||
                           (tx_p2_reg < x_lower_reg && vx_p2_reg < 20'sd0) ||
                           (ty_p2_reg > y_upper_reg && vy_p2_reg > 20'sd0) ||
                           (ty_p2_reg < y_lower_reg && vy_p2_reg < 20'sd0);
        end
    end

    // P4: combine the outer-link numerator, settle the flags
    logic signed [59:0] sum_r, shr;
    assign sum_r = mlp_reg + mlq_reg;
    assign shr   = (sum_r + 60'sd32768) >>> 16;

    logic signed [43:0] r_reg;
    logic signed [63:0] num1_p4_reg;
    logic signed [51:0] d1_p4_reg;
    logic signed [55:0] d2_p4_reg;
    side_t              side_p4_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            r_reg                 <= shr[43:0];
            num1_p4_reg           <= num1_p3_reg;
            d1_p4_reg             <= d1_p3_reg;
            d2_p4_reg             <= d2_reg;
            side_p4_reg.tip_x     <= tx_p3_reg;
            side_p4_reg.tip_y     <= ty_p3_reg;
            side_p4_reg.limit_hit <= lim_p3_reg;
            side_p4_reg.singular  <= !lim_p3_reg &&
                                     (sing_p3_reg || d2_reg == '0);
        end
    end

    // P5: scale the elbow numerator
    logic signed [66:0] r_deg;
    assign r_deg = r_reg * DEG_PER_RAD;

    logic signed [67:0] num2_reg;
    logic signed [63:0] num1_p5_reg;
    logic signed [51:0] d1_p5_reg;
    logic signed [55:0] d2_p5_reg;
    side_t              side_p5_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            num2_reg    <= -{r_deg[66], r_deg};
            num1_p5_reg <= num1_p4_reg;
            d1_p5_reg   <= d1_p4_reg;
            d2_p5_reg   <= d2_p4_reg;
            side_p5_reg <= side_p4_reg;
        end
    end

    // Quotient pipelines
    logic [31:0] q1, q2;
    logic        ovf1, ovf2, neg1, neg2;

    pavk_div #(.NUM_W(64), .DEN_W(52), .SHIFT(6)) u_div_shoulder (
        .aclk(aclk), .en(adv), .num(num1_p5_reg), .den(d1_p5_reg),
        .quot(q1), .ovf(ovf1), .neg(neg1));
    pavk_div #(.NUM_W(68), .DEN_W(56), .SHIFT(8)) u_div_elbow (
        .aclk(aclk), .en(adv), .num(num2_reg), .den(d2_p5_reg),
        .quot(q2), .ovf(ovf2), .neg(neg2));

    side_t side_d [0:32];
    always_ff @(posedge aclk) begin
        if (adv) begin
            side_d[0] <= side_p5_reg;
            for (int i = 1; i <= 32; i++) side_d[i] <= side_d[i-1];
        end
    end

    // Saturate to 32 bits and zero the speeds on a blocked word
    function automatic logic [31:0] sat_speed(input logic [31:0] q,
                                              input logic ovf_in,
                                              input logic neg_in);
        logic [31:0] val;
        if (neg_in) begin
            val = (ovf_in || q > 32'h8000_0000) ? 32'h8000_0000 : -q;
        end else begin
            val = (ovf_in || q[31]) ? 32'h7FFF_FFFF : q;
        end
        return val;
    endfunction

    side_t       side_out;
    logic        blocked;
    logic [31:0] w1_next, w2_next;
    always_comb begin
        side_out = side_d[32];
        blocked  = side_out.limit_hit || side_out.singular;
        w1_next  = blocked ? 32'd0 : sat_speed(q1, ovf1, neg1);
        w2_next  = blocked ? 32'd0 : sat_speed(q2, ovf2, neg2);
    end

    // Output register
    logic [103:0] tdata_reg;
    logic [1:0]   tuser_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            tdata_reg <= {2'b00, side_out.tip_y, side_out.tip_x, w2_next, w1_next};
            tuser_reg <= {side_out.singular, side_out.limit_hit};
        end
    end
    assign m_tdata = tdata_reg;
    assign m_tuser = tuser_reg;

    // Checks
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("limit_hit and singular both set");

    a_blocked_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] || m_tuser[1]) |-> m_tdata[63:0] == 64'd0)
        else $error("blocked word carries nonzero joint speed");

    a_hold_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("pipeline moved while output stalled");

endmodule
